// ----- rtl/cdsec_pkg.sv -----
// cdsec_pkg: shared constants, types and GF(2^8) helpers for the sector regenerator
// no dependencies
`default_nettype none
package cdsec_pkg;

    localparam int unsigned SECTOR_BYTES = 2352;
    localparam int unsigned SECTOR_WORDS = 294;
    localparam logic [31:0] EDC_POLY     = 32'hD801_8001;
    localparam logic [8:0]  GF_POLY      = 9'h11D;

    typedef enum logic [1:0] {
        TYPE_RAW   = 2'd0,
        TYPE_MODE1 = 2'd1,
        TYPE_FORM1 = 2'd2,
        TYPE_FORM2 = 2'd3
    } sector_type_t;

    // job handed from the loader to the regeneration engine
    typedef struct packed {
        logic [1:0]  stype;
        logic [31:0] edc;
    } cdsec_job_t;

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    // one byte of the reflected crc, eight dependent narrow steps
    function automatic logic [31:0] edc_byte(input logic [31:0] edc, input logic [7:0] b);
        logic [31:0] e;
        e = edc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            e = (e >> 1) ^ (e[0] ? EDC_POLY : 32'h0);
        end
        edc_byte = e;
    endfunction

    // inverse of x -> x*3: x*3^-1 is a linear map, built as xor of basis images
    function automatic logic [7:0] gf_div3(input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] basis [8];
        basis[0] = 8'hF4; basis[1] = 8'hF5; basis[2] = 8'hF7; basis[3] = 8'hF3;
        basis[4] = 8'hFB; basis[5] = 8'hEB; basis[6] = 8'hCB; basis[7] = 8'h8B;
        r = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) begin
                r = r ^ basis[k];
            end
        end
        gf_div3 = r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cdrom_sector_edc_ecc_generator.sv -----
// cdrom_sector_edc_ecc_generator: top level, joins the loader and the parity engine
// depends on cdsec_pkg, cdsec_loader, cdsec_engine
//
// channel | direction | tdata fields (low bit up)            | tuser / tlast
// s_      | in        | sector_word[63:0]                     | tuser: sector_type
// m_      | out       | word_index[8:0], tail_word[72:9]      | tlast: last_out
//
// one input word per cycle while s_tready is high; 294 words make a sector
// after the last word of an ecc sector the engine computes p and q parity,
// reading each source byte through the single store read port (ST_RD, ST_ACC)
// and writing each parity byte pair (ST_WP, ST_WQ); a form 2 sector needs only the
// edc write; each emitted word needs ST_ORD and ST_OUT plus any m_tready stall
// s_tready stays low from the last word of a non-raw sector until the engine has
// presented its final tail word; raw sectors never stall the input
// reset is synchronous, active low; clears loader control, engine state, out valid
`default_nettype none
module cdrom_sector_edc_ecc_generator
    import cdsec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // sector_word
    input  wire logic [1:0]  s_tuser,   // sector_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // word_index, tail_word
    output logic             m_tlast    // last_out
);

    logic        wr_en;
    logic [8:0]  wr_addr;
    logic [63:0] wr_data;
    logic        job_valid, job_take;
    logic        eng_busy;
    cdsec_job_t  job;
    logic [8:0]  out_index;
    logic [63:0] out_word;

    cdsec_loader u_loader (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_type(s_tuser), .in_word(s_tdata),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .job_take(job_take),
        .eng_busy(eng_busy)
    );

    cdsec_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .job_take(job_take),
        .busy(eng_busy),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_index(out_index), .out_word(out_word), .out_last(m_tlast)
    );

    assign m_tdata = {7'd0, out_word, out_index};

endmodule
`default_nettype wire

// ----- rtl/cdsec_loader.sv -----
// cdsec_loader: front part, counts words, latches type, runs the edc and writes words
// depends on cdsec_pkg
`default_nettype none
module cdsec_loader
    import cdsec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_type,
    input  wire logic [63:0] in_word,
    // word write into the store
    output logic             wr_en,
    output logic [8:0]       wr_addr,
    output logic [63:0]      wr_data,
    // job queue slot
    output logic             job_valid,
    output cdsec_job_t       job,
    input  wire logic        job_take,
    // engine owns the store port while it works on a sector
    input  wire logic        eng_busy
);

    logic [8:0]  wcnt_reg, wcnt_next;
    logic [1:0]  type_reg, type_next;
    logic [31:0] edc_reg, edc_next;
    logic        job_valid_reg, job_valid_next;
    cdsec_job_t  job_reg, job_next;
    logic [1:0]  cur_type;
    logic [31:0] edc_base;
    logic        accept;

    // one-entry queue: hold off input while a job waits or the engine uses the store
    assign in_ready = !(job_valid_reg || eng_busy);
    assign accept   = in_valid && in_ready;
    assign cur_type = (wcnt_reg == 9'd0) ? in_type : type_reg;
    assign edc_base = (wcnt_reg == 9'd0) ? 32'h0 : edc_reg;

    assign wr_en   = accept;
    assign wr_addr = wcnt_reg;
    assign wr_data = in_word;

    // edc over the byte range of the sector type
    always_comb begin
        logic [11:0] a;
        logic        on;
        edc_next = edc_base;
        for (int k = 0; k < 8; k++) begin
            a = {wcnt_reg, 3'b000} + 12'(k);
            case (cur_type)
                TYPE_MODE1: on = (a <= 12'h80F);
                TYPE_FORM1: on = (a >= 12'h010) && (a <= 12'h817);
                TYPE_FORM2: on = (a >= 12'h010) && (a <= 12'h92B);
                default:    on = 1'b0;
            endcase
            if (on) begin
                edc_next = edc_byte(edc_next, in_word[8*k +: 8]);
            end
        end
    end

    always_comb begin
        wcnt_next      = wcnt_reg;
        type_next      = type_reg;
        job_valid_next = job_valid_reg && !job_take;
        job_next       = job_reg;
        if (accept) begin
            type_next = cur_type;
            if (wcnt_reg == 9'(SECTOR_WORDS - 1)) begin
                wcnt_next = 9'd0;
                if (cur_type != TYPE_RAW) begin
                    job_valid_next = 1'b1;
                    job_next.stype = cur_type;
                    job_next.edc   = edc_next;
                end
            end else begin
                wcnt_next = wcnt_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg      <= 9'd0;
            type_reg      <= 2'd0;
            edc_reg       <= 32'h0;
            job_valid_reg <= 1'b0;
        end else begin
            wcnt_reg      <= wcnt_next;
            type_reg      <= type_next;
            job_valid_reg <= job_valid_next;
            if (accept) begin
                edc_reg <= edc_next;
            end
        end
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule
`default_nettype wire

// ----- rtl/cdsec_engine.sv -----
// cdsec_engine: back part, byte store, p/q parity sequencer and tail emission
// depends on cdsec_pkg
`default_nettype none
module cdsec_engine
    import cdsec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        wr_en,
    input  wire logic [8:0]  wr_addr,
    input  wire logic [63:0] wr_data,
    input  wire logic        job_valid,
    input  wire cdsec_job_t  job,
    output logic             job_take,
    output logic             busy,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [8:0]       out_index,
    output logic [63:0]      out_word,
    output logic             out_last
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDC, ST_RES, ST_RD, ST_ACC, ST_WP, ST_WQ, ST_ORD, ST_OUT
    } state_t;

    // store as 294 words with byte enables
    logic [63:0] mem [SECTOR_WORDS];
    logic [63:0] rdata_reg;

    state_t      state_reg;
    logic [1:0]  stype_reg;
    logic [31:0] edc_reg;
    logic        pass_reg;        // 0 p, 1 q
    logic [6:0]  major_reg;
    logic [5:0]  minor_reg;
    logic [11:0] idx_reg;
    logic [11:0] rel_reg;         // byte offset of the pending read
    logic [7:0]  a_reg, b_reg;
    logic [8:0]  ow_reg;
    logic [8:0]  oidx_reg;
    logic        ov_reg;
    logic [63:0] ow_data_reg;
    logic        olast_reg;

    // port signals
    logic        m_we;
    logic [8:0]  m_waddr;
    logic [63:0] m_wdata;
    logic [7:0]  m_be;
    logic [8:0]  m_raddr;

    logic [6:0]  mcount, mmult;
    logic [5:0]  ncount;
    logic [11:0] ninc, psize, dest, nidx, paddr;
    logic [7:0]  t_byte, a_acc, b_acc, pa;

    always_ff @(posedge aclk) begin
        if (m_we) begin
            for (int k = 0; k < 8; k++) begin
                if (m_be[k]) begin
                    mem[m_waddr][8*k +: 8] <= m_wdata[8*k +: 8];
                end
            end
        end
        rdata_reg <= mem[m_raddr];
    end

    assign mcount = pass_reg ? 7'd52 : 7'd86;
    assign ncount = pass_reg ? 6'd43 : 6'd24;
    assign mmult  = pass_reg ? 7'd86 : 7'd2;
    assign ninc   = pass_reg ? 12'd88 : 12'd86;
    assign psize  = pass_reg ? 12'd2236 : 12'd2064;
    assign dest   = pass_reg ? 12'h8C8 : 12'h81C;

    // next parity source index, wrapping by one compare and subtract
    assign nidx = (idx_reg + ninc >= psize) ? idx_reg + ninc - psize : idx_reg + ninc;

    // source byte: form 1 zeroes the address, beyond the sector reads zero
    always_comb begin
        t_byte = rdata_reg[8*rel_reg[2:0] +: 8];
        if ((stype_reg == TYPE_FORM1 && rel_reg < 12'd16 && rel_reg >= 12'd12)
            || rel_reg >= 12'(SECTOR_BYTES)) begin
            t_byte = 8'h00;
        end
        a_acc = gf_dbl(a_reg ^ t_byte);
        b_acc = b_reg ^ t_byte;
        pa    = gf_div3(gf_dbl(a_reg) ^ b_reg);
    end

    // store port arbitration
    always_comb begin
        m_we    = wr_en;
        m_waddr = wr_addr;
        m_wdata = wr_data;
        m_be    = 8'hFF;
        m_raddr = 9'd0;
        paddr   = 12'h000;
        unique case (state_reg)
            ST_EDC: begin
                m_we = 1'b1;
                unique case (stype_reg)
                    TYPE_MODE1: begin
                        // edc at 0x810-0x813, reserved 0x814-0x817 cleared alongside
                        m_waddr = 9'h102; m_wdata = {32'h0, edc_reg}; m_be = 8'hFF;
                    end
                    TYPE_FORM1: begin
                        m_waddr = 9'h103; m_wdata = {32'h0, edc_reg}; m_be = 8'h0F;
                    end
                    default: begin
                        m_waddr = 9'h125; m_wdata = {edc_reg, 32'h0}; m_be = 8'hF0;
                    end
                endcase
            end
            ST_RES: begin
                // rest of the mode 1 reserved bytes, 0x818-0x81b
                m_we = 1'b1; m_waddr = 9'h103; m_wdata = 64'h0; m_be = 8'h0F;
            end
            ST_WP: begin
                paddr = dest + {5'd0, major_reg};
                m_we = 1'b1; m_waddr = paddr[11:3];
                m_wdata = {8{pa}}; m_be = 8'h01 << paddr[2:0];
            end
            ST_WQ: begin
                paddr = dest + {5'd0, major_reg} + {5'd0, mcount};
                m_we = 1'b1; m_waddr = paddr[11:3];
                m_wdata = {8{pa ^ b_reg}}; m_be = 8'h01 << paddr[2:0];
            end
            default: begin
                paddr = 12'h00C + idx_reg;
            end
        endcase
        if (state_reg == ST_ORD || state_reg == ST_OUT) begin
            m_raddr = ow_reg;
        end else if (paddr < 12'(SECTOR_BYTES)) begin
            m_raddr = paddr[11:3];
        end
    end

    assign job_take  = (state_reg == ST_IDLE) && job_valid;
    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;
    assign out_index = oidx_reg;
    assign out_word  = ow_data_reg;
    assign out_last  = olast_reg;

    // sequencer: edc write, reserved clear (mode 1), p and q passes (mode 1 and form 1), emission
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        stype_reg <= job.stype;
                        edc_reg   <= job.edc;
                        state_reg <= ST_EDC;
                    end
                end
                ST_EDC: begin
                    pass_reg  <= 1'b0;
                    major_reg <= 7'd0;
                    minor_reg <= 6'd0;
                    idx_reg   <= 12'd0;
                    a_reg     <= 8'h00;
                    b_reg     <= 8'h00;
                    if (stype_reg == TYPE_MODE1) begin
                        state_reg <= ST_RES;
                    end else if (stype_reg == TYPE_FORM1) begin
                        state_reg <= ST_RD;
                    end else begin
                        ow_reg    <= 9'd293;
                        state_reg <= ST_ORD;
                    end
                end
                ST_RES: state_reg <= ST_RD;
                ST_RD: begin
                    rel_reg   <= 12'h00C + idx_reg;
                    idx_reg   <= nidx;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    a_reg <= a_acc;
                    b_reg <= b_acc;
                    if (minor_reg == ncount - 6'd1) begin
                        state_reg <= ST_WP;
                    end else begin
                        minor_reg <= minor_reg + 6'd1;
                        state_reg <= ST_RD;
                    end
                end
                ST_WP: state_reg <= ST_WQ;
                ST_WQ: begin
                    minor_reg <= 6'd0;
                    a_reg     <= 8'h00;
                    b_reg     <= 8'h00;
                    if (major_reg == mcount - 7'd1) begin
                        major_reg <= 7'd0;
                        idx_reg   <= 12'd0;
                        if (pass_reg) begin
                            ow_reg    <= (stype_reg == TYPE_MODE1) ? 9'd258 : 9'd259;
                            state_reg <= ST_ORD;
                        end else begin
                            pass_reg  <= 1'b1;
                            state_reg <= ST_RD;
                        end
                    end else begin
                        major_reg <= major_reg + 7'd1;
                        idx_reg   <= {5'd0, (major_reg + 7'd1) >> 1} * {5'd0, mmult}
                                   + {11'd0, ~major_reg[0]};
                        state_reg <= ST_RD;
                    end
                end
                ST_ORD: begin
                    if (!ov_reg || out_ready) begin
                        ov_reg    <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    ov_reg      <= 1'b1;
                    ow_data_reg <= rdata_reg;
                    oidx_reg    <= ow_reg;
                    olast_reg   <= (ow_reg == 9'(SECTOR_WORDS - 1));
                    if (ow_reg == 9'(SECTOR_WORDS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_ORD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (ov_reg && out_ready && state_reg != ST_ORD) begin
                ov_reg <= 1'b0;
            end
            if (state_reg == ST_ORD && (!ov_reg || out_ready) && ow_reg != 9'd0) begin
                ow_reg <= ow_reg;
            end
            if (state_reg == ST_OUT && ow_reg != 9'(SECTOR_WORDS - 1)) begin
                ow_reg <= ow_reg + 9'd1;
            end
        end
    end

endmodule
`default_nettype wire
